/* design/dq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dq_pkg
// Shared types and codes for the double-ended queue and its storage cells.
// ----------------------------------------------------------------------------
package dq_pkg;

    localparam int unsigned DATA_W   = 32;
    localparam int unsigned REQ_W    = 3;
    localparam int unsigned STATUS_W = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_INS_FRONT = 3'd0,
        REQ_INS_BACK  = 3'd1,
        REQ_REM_BACK  = 3'd2,
        REQ_REM_FRONT = 3'd3,
        REQ_DUMP      = 3'd4
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_DUMP = 2'b10
    } t_state;

    // One operation per cycle, broadcast to every cell.
    typedef struct packed {
        logic shift_r;    // insert at front: every cell takes its left neighbor
        logic shift_l;    // remove at front: every cell takes its right neighbor
        logic rotate;     // dump step: rotate the occupied cells by one
        logic push_back;  // insert at back: the cell at the fill level loads
    } t_cell_op;

endpackage
`default_nettype wire

/* design/dq_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dq_cell
// One storage cell of the queue row. Holds one entry and loads from a
// neighbor, from the front cell or from the request value.
// ----------------------------------------------------------------------------
module dq_cell #(
    parameter int IDX = 0,
    parameter int CW  = 5
) (
    input  wire logic                        i_clk,
    input  wire dq_pkg::t_cell_op            i_op,
    input  wire logic [CW-1:0]               i_count,
    input  wire logic signed [dq_pkg::DATA_W-1:0] i_value,
    input  wire logic signed [dq_pkg::DATA_W-1:0] i_left,
    input  wire logic signed [dq_pkg::DATA_W-1:0] i_right,
    input  wire logic signed [dq_pkg::DATA_W-1:0] i_front,
    output logic signed [dq_pkg::DATA_W-1:0]      o_data
);
    import dq_pkg::*;

    localparam logic [CW-1:0] L_IDX  = CW'(IDX);
    localparam logic [CW-1:0] L_IDX1 = CW'(IDX + 1);

    logic signed [DATA_W-1:0] r_data;
    logic signed [DATA_W-1:0] n_data;

    always_comb begin
        n_data = r_data;
        if (i_op.shift_r) begin
            n_data = i_left;
        end else if (i_op.shift_l) begin
            n_data = i_right;
        end else if (i_op.rotate) begin
            // last occupied cell wraps around to the front entry
            n_data = (L_IDX1 == i_count) ? i_front : i_right;
        end else if (i_op.push_back && (L_IDX == i_count)) begin
            n_data = i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule
`default_nettype wire

/* design/double_ended_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded deque of signed 32-bit entries held in a row of shift cells,
// front entry in cell 0. Inserts, removes and dumps from front to back.
// ----------------------------------------------------------------------------
// A taken transaction's result is registered and shows in the cycle after; a
// dump's first entry is registered from cell 0 once the state is in S_DUMP.
// Insert, remove and unused codes: a new request every cycle while not busy.
// Dump of N entries: busy while the cell row rotates one entry per cycle past
// cell 0; results stream one per cycle, the last flagged.
// Reset clears fill count and control; cell contents are undefined until
// written. Results cannot be stalled by the receiver.
module double_ended_queue #(
    parameter int DEPTH = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [dq_pkg::REQ_W-1:0]          i_req_type,
    input  wire logic signed [dq_pkg::DATA_W-1:0]  i_value,
    output logic                                   o_strobe,
    output logic [dq_pkg::STATUS_W-1:0]            o_status,
    output logic signed [dq_pkg::DATA_W-1:0]       o_entry_value,
    output logic                                   o_entry_valid,
    output logic [$clog2(DEPTH+1)-1:0]             o_occupancy,
    output logic                                   o_last
);
    import dq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] L_DEPTH = CW'(DEPTH);
    localparam logic [CW-1:0] L_ONE   = CW'(1);

    t_state                   r_state, n_state;
    logic [CW-1:0]            r_count, n_count;
    logic [CW-1:0]            r_dump_idx, n_dump_idx;
    logic                     r_strobe, n_strobe;
    t_status                  r_status, n_status;
    logic signed [DATA_W-1:0] r_entry_value, n_entry_value;
    logic                     r_entry_valid, n_entry_valid;
    logic                     r_last, n_last;
    t_cell_op                 w_op;
    logic                     w_take;
    logic signed [DATA_W-1:0] w_cell [DEPTH];

    assign busy   = (r_state == S_DUMP);
    assign w_take = start && !busy;

    // ---- cell row ----
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [DATA_W-1:0] w_left, w_right;
        if (g == 0) begin : g_first
            assign w_left = i_value;
        end else begin : g_mid_l
            assign w_left = w_cell[g-1];
        end
        if (g == DEPTH - 1) begin : g_end
            assign w_right = w_cell[g];
        end else begin : g_mid_r
            assign w_right = w_cell[g+1];
        end
        dq_cell #(
            .IDX (g),
            .CW  (CW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_op    (w_op),
            .i_count (r_count),
            .i_value (i_value),
            .i_left  (w_left),
            .i_right (w_right),
            .i_front (w_cell[0]),
            .o_data  (w_cell[g])
        );
    end

    // ---- request control ----
    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_dump_idx    = r_dump_idx;
        n_strobe      = 1'b0;
        n_status      = ST_OK;
        n_entry_value = '0;
        n_entry_valid = 1'b0;
        n_last        = 1'b1;
        w_op          = '0;

        case (r_state)
            S_IDLE: begin
                if (w_take) begin
                    n_strobe = 1'b1;
                    case (t_req'(i_req_type))
                        REQ_INS_FRONT: begin
                            if (r_count == L_DEPTH) begin
                                n_status = ST_FULL;
                            end else begin
                                w_op.shift_r = 1'b1;
                                n_count      = r_count + L_ONE;
                            end
                        end
                        REQ_INS_BACK: begin
                            if (r_count == L_DEPTH) begin
                                n_status = ST_FULL;
                            end else begin
                                w_op.push_back = 1'b1;
                                n_count        = r_count + L_ONE;
                            end
                        end
                        REQ_REM_BACK: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_count = r_count - L_ONE;
                            end
                        end
                        REQ_REM_FRONT: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                w_op.shift_l = 1'b1;
                                n_count      = r_count - L_ONE;
                            end
                        end
                        REQ_DUMP: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                // results come from the dump walk instead
                                n_strobe   = 1'b0;
                                n_dump_idx = '0;
                                n_state    = S_DUMP;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_DUMP: begin
                // emit front cell, then rotate the occupied cells by one
                w_op.rotate   = 1'b1;
                n_strobe      = 1'b1;
                n_entry_value = w_cell[0];
                n_entry_valid = 1'b1;
                n_dump_idx    = r_dump_idx + L_ONE;
                n_last        = (r_dump_idx + L_ONE == r_count);
                if (n_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_dump_idx <= '0;
            r_strobe   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_dump_idx <= n_dump_idx;
            r_strobe   <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status      <= n_status;
        r_entry_value <= n_entry_value;
        r_entry_valid <= n_entry_valid;
        r_last        <= n_last;
    end

    assign o_strobe      = r_strobe;
    assign o_status      = r_status;
    assign o_entry_value = r_entry_value;
    assign o_entry_valid = r_entry_valid;
    assign o_occupancy   = r_count;
    assign o_last        = r_last;

    // ---- assertions ----
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= L_DEPTH)
        else $error("fill count exceeds depth");

    a_dump_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> (r_count != '0) && (r_dump_idx < r_count))
        else $error("dump walk outside occupied cells");

    a_dump_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_entry_valid && o_last) |-> !busy)
        else $error("dump still running after its last entry");

    a_dump_mid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_entry_valid && !o_last) |-> busy)
        else $error("dump ended before its last entry");

endmodule
`default_nettype wire
